// File: design/trace_packet_parser_defines.svh
// Assertion macros for the trace packet parser, included by the back part.
`ifndef TRACE_PACKET_PARSER_DEFINES_SVH
`define TRACE_PACKET_PARSER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define TPP_ASSERT_IMPL(label, clk_i, rst_n, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TPP_ASSERT_NEXT(label, clk_i, rst_n, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: design/tpp_pkg.sv
// Package with shared types, codes and the header classifier of the trace packet parser.
package tpp_pkg;
	localparam int QueueDepth = 2;

	localparam logic [4:0] KIND_BRANCH = 5'd0;
	localparam logic [4:0] KIND_ALIGN = 5'd1;
	localparam logic [4:0] KIND_CYCLE = 5'd2;
	localparam logic [4:0] KIND_ISYNC = 5'd3;
	localparam logic [4:0] KIND_TRIGGER = 5'd4;
	localparam logic [4:0] KIND_OOO = 5'd5;
	localparam logic [4:0] KIND_STFAIL = 5'd6;
	localparam logic [4:0] KIND_ISYNC_CYC = 5'd7;
	localparam logic [4:0] KIND_BAD_INFO = 5'd8;
	localparam logic [4:0] KIND_PLACEHOLDER = 5'd9;
	localparam logic [4:0] KIND_DATA = 5'd10;
	localparam logic [4:0] KIND_SUPPRESSED = 5'd11;
	localparam logic [4:0] KIND_IGNORE = 5'd12;
	localparam logic [4:0] KIND_NOT_TRACED = 5'd13;
	localparam logic [4:0] KIND_CONTEXT = 5'd14;
	localparam logic [4:0] KIND_EXC_EXIT = 5'd15;
	localparam logic [4:0] KIND_EXC_ENTRY = 5'd16;
	localparam logic [4:0] KIND_RESERVED = 5'd17;
	localparam logic [4:0] KIND_PHEADER = 5'd18;
	localparam logic [4:0] KIND_BAD_PHEADER = 5'd19;

	localparam logic [0:0] REG_CONTEXT_SIZE = 1'b0;
	localparam logic [0:0] REG_ATOM_TIMING = 1'b1;

	// Word carried from the classifier to the packet sequencer.
	typedef struct packed {
		logic [7:0] hbyte;
		logic [4:0] kind;
	} cls_word_t;

	// Header classification, first match in table order.
	function automatic logic [4:0] classify(input logic [7:0] b);
		logic [4:0] k;
		k = KIND_RESERVED;
		if (b[0]) k = KIND_BRANCH;
		else if (b == 8'h00) k = KIND_ALIGN;
		else if (b == 8'h04) k = KIND_CYCLE;
		else if (b == 8'h08) k = KIND_ISYNC;
		else if (b == 8'h0c) k = KIND_TRIGGER;
		else if ((b & 8'h93) == 8'h00) k = KIND_OOO;
		else if (b == 8'h50) k = KIND_STFAIL;
		else if (b == 8'h70) k = KIND_ISYNC_CYC;
		else if ((b & 8'hd3) == 8'h50) k = KIND_PLACEHOLDER;
		else if ((b & 8'hd3) == 8'h12) k = KIND_RESERVED;
		else if ((b & 8'hf3) == 8'h10) k = KIND_RESERVED;
		else if ((b & 8'hf3) == 8'h30) k = KIND_RESERVED;
		else if ((b & 8'hd3) == 8'h02) k = KIND_DATA;
		else if ((b & 8'he3) == 8'h42) k = KIND_RESERVED;
		else if (b == 8'h62) k = KIND_SUPPRESSED;
		else if (b == 8'h66) k = KIND_IGNORE;
		else if ((b & 8'hef) == 8'h6a) k = KIND_NOT_TRACED;
		else if (b == 8'h6e) k = KIND_CONTEXT;
		else if (b == 8'h76) k = KIND_EXC_EXIT;
		else if (b == 8'h7e) k = KIND_EXC_ENTRY;
		else if ((b & 8'hf3) == 8'h72) k = KIND_RESERVED;
		else if ((b & 8'h81) == 8'h80) k = KIND_PHEADER;
		return k;
	endfunction
endpackage

// File: design/tpp_front.sv
// Front part: takes stream bytes and tags each with its header class.
module tpp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	output logic                in_stall,
	output logic                cw_valid,
	output tpp_pkg::cls_word_t  cw,
	input  logic                cw_stall
);
	logic               valid_q;
	tpp_pkg::cls_word_t word_q;

	// Skid-free output register: refill whenever empty or drained.
	assign in_stall = valid_q && cw_stall;
	assign cw_valid = valid_q;
	assign cw = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_q.hbyte <= in_byte;
			word_q.kind <= tpp_pkg::classify(in_byte);
		end
	end
endmodule

// File: design/tpp_queue.sv
// Short queue between the front and back parts.
module tpp_queue #(
	parameter int Depth = tpp_pkg::QueueDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	input  tpp_pkg::cls_word_t  wr_word,
	output logic                wr_stall,
	output logic                rd_valid,
	output tpp_pkg::cls_word_t  rd_word,
	input  logic                rd_stall
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	tpp_pkg::cls_word_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          push, pop;

	assign wr_stall = (cnt_q == (AW+1)'(Depth));
	assign rd_valid = (cnt_q != '0);
	assign rd_word = mem_q[rp_q];
	assign push = wr_valid && !wr_stall;
	assign pop = rd_valid && !rd_stall;

	// Pointer and fill count update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_word;
	end
endmodule

// File: design/tpp_back.sv
// Back part: gathers packet payload bytes and emits finished packets.
`include "trace_packet_parser_defines.svh"
module tpp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          context_size,
	input  logic                atom_timing,
	input  logic                cw_valid,
	input  tpp_pkg::cls_word_t  cw,
	output logic                cw_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [4:0]          packet_kind,
	output logic [31:0]         address,
	output logic [4:0]          address_bits,
	output logic [31:0]         cycle_value,
	output logic [31:0]         context_value,
	output logic [31:0]         info_or_data,
	output logic [1:0]          data_size,
	output logic [1:0]          data_tag,
	output logic [4:0]          atom_count,
	output logic [15:0]         atom_executed,
	output logic                atoms_cycle_marked
);
	localparam logic [3:0] PH_HEADER = 4'd0;
	localparam logic [3:0] PH_BRANCH = 4'd1;
	localparam logic [3:0] PH_CYCLE = 4'd2;
	localparam logic [3:0] PH_IS_CTX = 4'd3;
	localparam logic [3:0] PH_IS_INFO = 4'd4;
	localparam logic [3:0] PH_IS_ADDR = 4'd5;
	localparam logic [3:0] PH_IC_CYCLE = 4'd6;
	localparam logic [3:0] PH_IC_CTX = 4'd7;
	localparam logic [3:0] PH_IC_INFO = 4'd8;
	localparam logic [3:0] PH_IC_ADDR = 4'd9;
	localparam logic [3:0] PH_OOO = 4'd10;
	localparam logic [3:0] PH_DADDR = 4'd11;
	localparam logic [3:0] PH_CTX = 4'd12;

	logic [3:0]  phase_q, phase_d;
	logic [7:0]  hdr_q, hdr_d;
	logic [2:0]  idx_q, idx_d;
	logic [31:0] addr_q, addr_d, cyc_q, cyc_d, ctx_q, ctx_d, dat_q, dat_d;
	logic [7:0]  info_q, info_d;
	logic        emit;
	logic [4:0]  o_kind, o_abits, o_n;
	logic [31:0] o_cyc;
	logic [15:0] o_ex;
	logic        o_mark;
	logic        ovalid_q;
	logic [2:0]  clen;
	logic        take;
	logic [7:0]  b;
	logic [4:0]  sh7;
	logic [4:0]  sh8;
	logic [5:0]  e_cnt;
	logic        g7_done;
	logic [31:0] g7_val;
	logic [31:0] r_addr, r_cyc, r_ctx, r_info;
	logic [4:0]  r_abits, r_n;
	logic [1:0]  r_dsize, r_dtag;
	logic [15:0] r_ex;
	logic        r_mark;

	assign clen = (context_size > 3'd4) ? 3'd4 : context_size;
	assign b = cw.hbyte;
	assign cw_stall = ovalid_q && out_stall;
	assign take = cw_valid && !cw_stall;
	assign out_valid = ovalid_q;
	assign sh8 = {idx_q[1:0], 3'b000};

	// Continuation-coded seven-bit group, shared by cycle and data address.
	always_comb begin
		sh7 = 5'(7 * idx_q[1:0]);
		if (idx_q >= 3'd4) begin
			g7_val = {b[3:0], 28'd0};
			g7_done = 1'b1;
		end else begin
			g7_val = 32'(b[6:0]) << sh7;
			g7_done = !b[7];
		end
	end

	// Packet sequencer next state and result formation.
	always_comb begin
		phase_d = phase_q; hdr_d = hdr_q; idx_d = idx_q;
		addr_d = addr_q; cyc_d = cyc_q; ctx_d = ctx_q; dat_d = dat_q; info_d = info_q;
		emit = 1'b0; o_kind = cw.kind; o_abits = '0; o_n = '0; o_cyc = '0;
		o_ex = '0; o_mark = 1'b0; e_cnt = '0;
		case (phase_q)
			PH_HEADER: begin
				hdr_d = b; idx_d = '0;
				addr_d = '0; cyc_d = '0; ctx_d = '0; dat_d = '0; info_d = '0;
				case (cw.kind)
					tpp_pkg::KIND_BRANCH: begin
						addr_d = {24'd0, b[6:0], 1'b0};
						if (b[7]) begin
							phase_d = PH_BRANCH; idx_d = 3'd1;
						end else begin
							emit = 1'b1; o_abits = 5'd7;
						end
					end
					tpp_pkg::KIND_CYCLE: phase_d = PH_CYCLE;
					tpp_pkg::KIND_ISYNC: phase_d = (clen != '0) ? PH_IS_CTX : PH_IS_INFO;
					tpp_pkg::KIND_OOO: begin
						if (b[3:2] == 2'd0) emit = 1'b1;
						else phase_d = PH_OOO;
					end
					tpp_pkg::KIND_ISYNC_CYC: phase_d = PH_IC_CYCLE;
					tpp_pkg::KIND_PLACEHOLDER, tpp_pkg::KIND_DATA: begin
						if (b[5]) phase_d = PH_DADDR;
						else emit = 1'b1;
					end
					tpp_pkg::KIND_CONTEXT: begin
						if (clen != '0) phase_d = PH_CTX;
						else emit = 1'b1;
					end
					tpp_pkg::KIND_PHEADER: begin
						emit = 1'b1;
						if (!atom_timing) begin
							if (b[1:0] == 2'b00) begin
								e_cnt = {2'b00, b[5:2]};
								o_n = 5'(e_cnt) + 5'(b[6]);
								o_ex = 16'((17'd1 << e_cnt) - 17'd1);
							end else if (b[1:0] == 2'b10) begin
								o_n = 5'd2;
								o_ex = {14'd0, b[2], b[3]};
							end
						end else if (b == 8'h80) begin
						end else if ((b & 8'ha3) == 8'h80) begin
							e_cnt = {3'b000, b[4:2]};
							o_n = 5'(e_cnt) + 5'(b[6]);
							o_ex = 16'((17'd1 << e_cnt) - 17'd1);
							o_mark = 1'b1;
						end else if ((b & 8'hf3) == 8'h82) begin
							o_cyc = 32'd1; o_n = 5'd2;
							o_ex = {14'd0, b[2], b[3]};
						end else if ((b & 8'ha3) == 8'ha0) begin
							o_cyc = {29'd0, b[4:2]};
							o_n = {4'd0, b[6]}; o_ex = {15'd0, b[6]};
						end else if ((b & 8'hfb) == 8'h92) begin
						end else begin
							o_kind = tpp_pkg::KIND_BAD_PHEADER;
						end
					end
					default: emit = 1'b1;
				endcase
			end
			PH_BRANCH: begin
				o_kind = tpp_pkg::KIND_BRANCH;
				if (idx_q >= 3'd4) begin
					addr_d = addr_q | {b[2:0], 29'd0};
					emit = 1'b1; o_abits = 5'd31;
				end else begin
					addr_d = addr_q | ((32'(b[6:0]) << sh7) << 1);
					if (b[7]) idx_d = idx_q + 3'd1;
					else begin
						emit = 1'b1; o_abits = 5'(7 * (idx_q + 3'd1));
					end
				end
			end
			PH_CYCLE: begin
				o_kind = tpp_pkg::KIND_CYCLE;
				cyc_d = cyc_q | g7_val;
				if (g7_done) emit = 1'b1;
				else idx_d = idx_q + 3'd1;
			end
			PH_IS_CTX, PH_IC_CTX, PH_CTX: begin
				o_kind = tpp_pkg::KIND_CONTEXT;
				ctx_d = ctx_q | (32'(b) << sh8);
				idx_d = idx_q + 3'd1;
				if (idx_d >= clen) begin
					idx_d = '0;
					if (phase_q == PH_IS_CTX) phase_d = PH_IS_INFO;
					else if (phase_q == PH_IC_CTX) phase_d = PH_IC_INFO;
					else emit = 1'b1;
				end
			end
			PH_IS_INFO: begin
				info_d = b; idx_d = '0; phase_d = PH_IS_ADDR;
			end
			PH_IS_ADDR, PH_IC_ADDR: begin
				o_kind = (phase_q == PH_IS_ADDR) ? tpp_pkg::KIND_ISYNC
					: tpp_pkg::KIND_ISYNC_CYC;
				addr_d = addr_q | (32'(b) << sh8);
				idx_d = idx_q + 3'd1;
				if (idx_d >= 3'd4) emit = 1'b1;
			end
			PH_IC_CYCLE: begin
				cyc_d = cyc_q | g7_val;
				if (g7_done) begin
					idx_d = '0;
					phase_d = (clen != '0) ? PH_IC_CTX : PH_IC_INFO;
				end else idx_d = idx_q + 3'd1;
			end
			PH_IC_INFO: begin
				info_d = b;
				o_kind = tpp_pkg::KIND_BAD_INFO;
				if ((b & 8'h9f) != 8'h09) emit = 1'b1;
				else begin
					idx_d = '0; phase_d = PH_IC_ADDR;
				end
			end
			PH_OOO: begin
				o_kind = tpp_pkg::KIND_OOO;
				dat_d = dat_q | (32'(b) << sh8);
				idx_d = idx_q + 3'd1;
				if (idx_d >= {1'b0, hdr_q[3:2]}) emit = 1'b1;
			end
			PH_DADDR: begin
				o_kind = ((hdr_q & 8'hd3) == 8'h50) ? tpp_pkg::KIND_PLACEHOLDER
					: tpp_pkg::KIND_DATA;
				addr_d = addr_q | g7_val;
				if (g7_done) emit = 1'b1;
				else idx_d = idx_q + 3'd1;
			end
			default: begin
				phase_d = PH_HEADER; idx_d = '0;
			end
		endcase
		if (emit) begin
			phase_d = PH_HEADER; idx_d = '0;
		end
	end

	// Result fields by kind; fields not used by a kind read zero.
	always_comb begin
		r_addr = '0; r_abits = '0; r_cyc = '0; r_ctx = '0; r_info = '0;
		r_dsize = '0; r_dtag = '0; r_n = '0; r_ex = '0; r_mark = 1'b0;
		case (o_kind)
			tpp_pkg::KIND_BRANCH: begin
				r_addr = addr_d & 32'hfffffffc; r_abits = o_abits;
			end
			tpp_pkg::KIND_CYCLE: r_cyc = cyc_d;
			tpp_pkg::KIND_ISYNC: begin
				r_addr = addr_d; r_ctx = ctx_d; r_info = {24'd0, info_d};
			end
			tpp_pkg::KIND_OOO: begin
				r_info = dat_d; r_dsize = hdr_d[3:2]; r_dtag = hdr_d[6:5];
			end
			tpp_pkg::KIND_ISYNC_CYC: begin
				r_addr = addr_d; r_cyc = cyc_d; r_ctx = ctx_d;
				r_info = {24'd0, info_d};
			end
			tpp_pkg::KIND_BAD_INFO: begin
				r_cyc = cyc_d; r_ctx = ctx_d; r_info = {24'd0, info_d};
			end
			tpp_pkg::KIND_PLACEHOLDER, tpp_pkg::KIND_DATA: r_addr = addr_d;
			tpp_pkg::KIND_CONTEXT: r_ctx = ctx_d;
			tpp_pkg::KIND_PHEADER: begin
				r_cyc = o_cyc; r_n = o_n; r_ex = o_ex; r_mark = o_mark;
			end
			default: ;
		endcase
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER; hdr_q <= '0; idx_q <= '0;
			addr_q <= '0; cyc_q <= '0; ctx_q <= '0; dat_q <= '0; info_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d; hdr_q <= hdr_d; idx_q <= idx_d;
				addr_q <= addr_d; cyc_q <= cyc_d; ctx_q <= ctx_d;
				dat_q <= dat_d; info_q <= info_d;
			end
			if (!cw_stall) ovalid_q <= take && emit;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (take && emit) begin
			packet_kind <= o_kind;
			address <= r_addr; address_bits <= r_abits; cycle_value <= r_cyc;
			context_value <= r_ctx; info_or_data <= r_info;
			data_size <= r_dsize; data_tag <= r_dtag;
			atom_count <= r_n; atom_executed <= r_ex; atoms_cycle_marked <= r_mark;
		end
	end

	`TPP_ASSERT_IMPL(a_idx_range, clk, arst_n, 1'b1, idx_q <= 3'd4)
	`TPP_ASSERT_NEXT(a_emit_valid, clk, arst_n, take && emit, out_valid)
	`TPP_ASSERT_NEXT(a_hold_result, clk, arst_n, out_valid && out_stall, out_valid)
	`TPP_ASSERT_IMPL(a_phase_legal, clk, arst_n, 1'b1, phase_q <= PH_CTX)
endmodule

// File: design/trace_packet_parser.sv
// Top level of the trace packet parser: front classifier, queue and packet sequencer.
// The packet's last byte passes the front register and the queue before the result register raises out_valid.
// Throughput: one stream word per cycle while neither the queue nor the output stalls.
// A two-entry queue lets the classifier keep taking words while the output stalls.
// Reset (arst_n low) clears the parse state, configuration registers and queue; the first word is a header.
module trace_packet_parser #(
	parameter int QueueDepth = tpp_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [2:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  stream_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  packet_kind,
	output logic [31:0] address,
	output logic [4:0]  address_bits,
	output logic [31:0] cycle_value,
	output logic [31:0] context_value,
	output logic [31:0] info_or_data,
	output logic [1:0]  data_size,
	output logic [1:0]  data_tag,
	output logic [4:0]  atom_count,
	output logic [15:0] atom_executed,
	output logic        atoms_cycle_marked
);
	logic [2:0] context_size_q;
	logic       atom_timing_q;
	logic       f_valid, f_stall, b_valid, b_stall;
	tpp_pkg::cls_word_t f_word, b_word;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			context_size_q <= '0;
			atom_timing_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tpp_pkg::REG_CONTEXT_SIZE: context_size_q <= cfg_data;
				tpp_pkg::REG_ATOM_TIMING: atom_timing_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tpp_front u_front (
		.clk, .arst_n, .in_valid, .in_byte(stream_byte), .in_stall,
		.cw_valid(f_valid), .cw(f_word), .cw_stall(f_stall)
	);

	tpp_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_word(f_word), .wr_stall(f_stall),
		.rd_valid(b_valid), .rd_word(b_word), .rd_stall(b_stall)
	);

	tpp_back u_back (
		.clk, .arst_n, .context_size(context_size_q), .atom_timing(atom_timing_q),
		.cw_valid(b_valid), .cw(b_word), .cw_stall(b_stall),
		.out_valid, .out_stall, .packet_kind, .address, .address_bits, .cycle_value,
		.context_value, .info_or_data, .data_size, .data_tag, .atom_count,
		.atom_executed, .atoms_cycle_marked
	);
endmodule

// File: test/testbench.sv
// Self-checking testbench for the trace packet parser with a byte-level decoder model.
`timescale 1ns / 100ps

module testbench;
	localparam int IdleLimit = 4000;
	localparam int Latency = 3;

	// One decoded packet as seen on the output port.
	typedef struct packed {
		logic [4:0]  kind;
		logic [31:0] addr;
		logic [4:0]  abits;
		logic [31:0] cyc;
		logic [31:0] ctx;
		logic [31:0] info;
		logic [1:0]  dsize;
		logic [1:0]  dtag;
		logic [4:0]  natoms;
		logic [15:0] executed;
		logic        marked;
	} packet_t;

	// Phases of the decoder model.
	typedef enum logic [3:0] {
		P_HEADER, P_BRANCH, P_CYCLE, P_IS_CTX, P_IS_INFO, P_IS_ADDR, P_IC_CYCLE,
		P_IC_CTX, P_IC_INFO, P_IC_ADDR, P_OOO, P_DADDR, P_CTX
	} phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = tpp_pkg::REG_CONTEXT_SIZE;
	logic [2:0] cfg_data = 3'd0;
	logic in_valid = 1'b0;
	logic [7:0] stream_byte = 8'd0;
	logic out_stall = 1'b0;
	logic in_stall, out_valid;
	logic [4:0] packet_kind, address_bits, atom_count;
	logic [31:0] address, cycle_value, context_value, info_or_data;
	logic [1:0] data_size, data_tag;
	logic [15:0] atom_executed;
	logic atoms_cycle_marked;

	trace_packet_parser dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Decoder model state.
	logic [2:0] m_ctx_size;
	logic m_cyc_acc;
	phase_t m_phase;
	logic [7:0] m_hdr;
	int unsigned m_idx;
	logic [31:0] m_addr, m_cyc, m_ctx, m_data;
	logic [7:0] m_info;

	logic [7:0] pending_words[$];
	packet_t expected_packets[$];
	int errors = 0;
	int packets_seen = 0;
	int words_sent = 0;

	function automatic int unsigned ctx_bytes();
		return (m_ctx_size > 4) ? 4 : m_ctx_size;
	endfunction

	function automatic logic [4:0] header_kind(logic [7:0] b);
		if (b[0]) return tpp_pkg::KIND_BRANCH;
		if (b == 8'h00) return tpp_pkg::KIND_ALIGN;
		if (b == 8'h04) return tpp_pkg::KIND_CYCLE;
		if (b == 8'h08) return tpp_pkg::KIND_ISYNC;
		if (b == 8'h0c) return tpp_pkg::KIND_TRIGGER;
		if ((b & 8'h93) == 8'h00) return tpp_pkg::KIND_OOO;
		if (b == 8'h50) return tpp_pkg::KIND_STFAIL;
		if (b == 8'h70) return tpp_pkg::KIND_ISYNC_CYC;
		if ((b & 8'hd3) == 8'h50) return tpp_pkg::KIND_PLACEHOLDER;
		if ((b & 8'hd3) == 8'h12 || (b & 8'hf3) == 8'h10 || (b & 8'hf3) == 8'h30)
			return tpp_pkg::KIND_RESERVED;
		if ((b & 8'hd3) == 8'h02) return tpp_pkg::KIND_DATA;
		if ((b & 8'he3) == 8'h42) return tpp_pkg::KIND_RESERVED;
		if (b == 8'h62) return tpp_pkg::KIND_SUPPRESSED;
		if (b == 8'h66) return tpp_pkg::KIND_IGNORE;
		if ((b & 8'hef) == 8'h6a) return tpp_pkg::KIND_NOT_TRACED;
		if (b == 8'h6e) return tpp_pkg::KIND_CONTEXT;
		if (b == 8'h76) return tpp_pkg::KIND_EXC_EXIT;
		if (b == 8'h7e) return tpp_pkg::KIND_EXC_ENTRY;
		if ((b & 8'h81) == 8'h80) return tpp_pkg::KIND_PHEADER;
		return tpp_pkg::KIND_RESERVED;
	endfunction

	// Continuation-coded field; returns 1 when the field is complete.
	function automatic bit take7(ref logic [31:0] acc, input logic [7:0] b);
		if (m_idx >= 4) begin
			acc |= 32'(b & 8'h0f) << 28;
			return 1;
		end
		acc |= 32'(b & 8'h7f) << (7 * m_idx);
		if (!b[7]) return 1;
		m_idx++;
		return 0;
	endfunction

	function automatic bit take_ctx(logic [7:0] b);
		m_ctx |= 32'(b) << (8 * (m_idx & 3));
		m_idx++;
		if (m_idx >= ctx_bytes()) begin
			m_idx = 0;
			return 1;
		end
		return 0;
	endfunction

	function automatic void close_packet(logic [4:0] k, packet_t p);
		p.kind = k;
		case (k)
			tpp_pkg::KIND_BRANCH: p.addr = m_addr & 32'hfffffffc;
			tpp_pkg::KIND_CYCLE: p.cyc = m_cyc;
			tpp_pkg::KIND_ISYNC: begin
				p.addr = m_addr; p.ctx = m_ctx; p.info = 32'(m_info);
			end
			tpp_pkg::KIND_OOO: begin
				p.info = m_data; p.dsize = m_hdr[3:2]; p.dtag = m_hdr[6:5];
			end
			tpp_pkg::KIND_ISYNC_CYC: begin
				p.addr = m_addr; p.cyc = m_cyc; p.ctx = m_ctx; p.info = 32'(m_info);
			end
			tpp_pkg::KIND_BAD_INFO: begin
				p.cyc = m_cyc; p.ctx = m_ctx; p.info = 32'(m_info);
			end
			tpp_pkg::KIND_PLACEHOLDER, tpp_pkg::KIND_DATA: p.addr = m_addr;
			tpp_pkg::KIND_CONTEXT: p.ctx = m_ctx;
			default: ;
		endcase
		m_phase = P_HEADER;
		m_idx = 0;
		expected_packets.push_back(p);
	endfunction

	function automatic void add_atom(ref packet_t p, input bit ex);
		if (p.natoms < 16) begin
			if (ex) p.executed[p.natoms] = 1'b1;
			p.natoms++;
		end
	endfunction

	// Expand an atom header into its atoms and wait cycles.
	function automatic void expand_pheader(logic [7:0] b);
		packet_t p = '0;
		logic [4:0] k = tpp_pkg::KIND_PHEADER;
		if (!m_cyc_acc) begin
			if ((b & 8'h83) == 8'h80) begin
				for (int i = 0; i < b[5:2]; i++) add_atom(p, 1);
				if (b[6]) add_atom(p, 0);
			end else if ((b & 8'h83) == 8'h82) begin
				add_atom(p, b[3]);
				add_atom(p, b[2]);
			end
		end else if (b == 8'h80) begin
		end else if ((b & 8'ha3) == 8'h80) begin
			for (int i = 0; i < b[4:2]; i++) add_atom(p, 1);
			if (b[6]) add_atom(p, 0);
			p.marked = 1'b1;
		end else if ((b & 8'hf3) == 8'h82) begin
			p.cyc = 1;
			add_atom(p, b[3]);
			add_atom(p, b[2]);
		end else if ((b & 8'ha3) == 8'ha0) begin
			p.cyc = 32'(b[4:2]);
			if (b[6]) add_atom(p, 1);
		end else if ((b & 8'hfb) == 8'h92) begin
		end else begin
			k = tpp_pkg::KIND_BAD_PHEADER;
			p = '0;
		end
		close_packet(k, p);
	endfunction

	// Advance the decoder model by one accepted word.
	function automatic void decode_word(logic [7:0] b);
		packet_t p = '0;
		logic [4:0] k;
		case (m_phase)
			P_HEADER: begin
				m_hdr = b; m_idx = 0;
				m_addr = 0; m_cyc = 0; m_ctx = 0; m_data = 0; m_info = 0;
				k = header_kind(b);
				case (k)
					tpp_pkg::KIND_BRANCH: begin
						m_addr = 32'(b & 8'h7f) << 1;
						if (b[7]) begin
							m_phase = P_BRANCH; m_idx = 1;
						end else begin
							p.abits = 7; close_packet(k, p);
						end
					end
					tpp_pkg::KIND_CYCLE: m_phase = P_CYCLE;
					tpp_pkg::KIND_ISYNC: m_phase = ctx_bytes() ? P_IS_CTX : P_IS_INFO;
					tpp_pkg::KIND_OOO:
						if (b[3:2] == 0) close_packet(k, p); else m_phase = P_OOO;
					tpp_pkg::KIND_ISYNC_CYC: m_phase = P_IC_CYCLE;
					tpp_pkg::KIND_PLACEHOLDER, tpp_pkg::KIND_DATA:
						if (b[5]) m_phase = P_DADDR; else close_packet(k, p);
					tpp_pkg::KIND_CONTEXT:
						if (ctx_bytes()) m_phase = P_CTX; else close_packet(k, p);
					tpp_pkg::KIND_PHEADER: expand_pheader(b);
					default: close_packet(k, p);
				endcase
			end
			P_BRANCH: begin
				if (m_idx >= 4) begin
					m_addr |= 32'(b & 8'h07) << 29;
					p.abits = 31;
					close_packet(tpp_pkg::KIND_BRANCH, p);
				end else begin
					m_addr |= 32'(b & 8'h7f) << (7 * m_idx + 1);
					if (b[7]) m_idx++;
					else begin
						p.abits = 5'(7 * (m_idx + 1));
						close_packet(tpp_pkg::KIND_BRANCH, p);
					end
				end
			end
			P_CYCLE: if (take7(m_cyc, b)) close_packet(tpp_pkg::KIND_CYCLE, p);
			P_IS_CTX: if (take_ctx(b)) m_phase = P_IS_INFO;
			P_IS_INFO: begin
				m_info = b; m_idx = 0; m_phase = P_IS_ADDR;
			end
			P_IS_ADDR, P_IC_ADDR: begin
				m_addr |= 32'(b) << (8 * (m_idx & 3));
				m_idx++;
				if (m_idx >= 4)
					close_packet(m_phase == P_IS_ADDR ? tpp_pkg::KIND_ISYNC
						: tpp_pkg::KIND_ISYNC_CYC, p);
			end
			P_IC_CYCLE: if (take7(m_cyc, b)) begin
				m_idx = 0;
				m_phase = ctx_bytes() ? P_IC_CTX : P_IC_INFO;
			end
			P_IC_CTX: if (take_ctx(b)) m_phase = P_IC_INFO;
			P_IC_INFO: begin
				m_info = b;
				if ((b & 8'h9f) != 8'h09) close_packet(tpp_pkg::KIND_BAD_INFO, p);
				else begin
					m_idx = 0; m_phase = P_IC_ADDR;
				end
			end
			P_OOO: begin
				m_data |= 32'(b) << (8 * (m_idx & 3));
				m_idx++;
				if (m_idx >= m_hdr[3:2]) close_packet(tpp_pkg::KIND_OOO, p);
			end
			P_DADDR: if (take7(m_addr, b))
				close_packet(((m_hdr & 8'hd3) == 8'h50) ? tpp_pkg::KIND_PLACEHOLDER
					: tpp_pkg::KIND_DATA, p);
			P_CTX: if (take_ctx(b)) close_packet(tpp_pkg::KIND_CONTEXT, p);
			default: begin
				m_phase = P_HEADER; m_idx = 0;
			end
		endcase
	endfunction

	// Driver: bursts of words separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				decode_word(stream_byte);
				words_sent++;
				void'(pending_words.pop_front());
			end
			if (in_valid && in_stall) begin
				// Hold the stalled word.
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_words.size() > ((in_valid && !in_stall) ? 0 : 0)) begin
				stream_byte <= pending_words[0];
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 30);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				end else
					burst_left <= burst_left - 1;
			end else
				in_valid <= 1'b0;
		end
	end

	// Receiver stall pattern: long clear stretches mixed with busy ones.
	int stall_phase = 0;
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if (stall_phase[7:6] == 2'b00) out_stall <= 1'b0;
		else if (stall_phase[7:6] == 2'b11) out_stall <= ($urandom_range(0, 1) == 0);
		else out_stall <= ($urandom_range(0, 4) == 0);
	end

	// Monitor: compare each result with the oldest expectation.
	always @(posedge clk) begin
		packet_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{packet_kind, address, address_bits, cycle_value, context_value,
				info_or_data, data_size, data_tag, atom_count, atom_executed,
				atoms_cycle_marked};
			packets_seen++;
			if (expected_packets.size() == 0) begin
				errors++;
				$display("%0t: unexpected packet, actual %p", $time, got);
			end else begin
				want = expected_packets.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: packet mismatch, expected %p, actual %p",
						$time, want, got);
				end
			end
		end
	end

	// Watchdog on cycles with no accepted word on either side.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic add_continued(int nbytes, bit last_full);
		for (int i = 0; i < nbytes; i++) begin
			logic [7:0] b = 8'($urandom);
			if (i < nbytes - 1) b[7] = 1'b1;
			else if (!last_full) b[7] = 1'b0;
			pending_words.push_back(b);
		end
	endtask

	task automatic add_random_bytes(int n);
		for (int i = 0; i < n; i++) pending_words.push_back(8'($urandom));
	endtask

	// One packet with random content; some headers and info bytes are malformed or reserved.
	task automatic add_packet();
		logic [7:0] h;
		case ($urandom_range(0, 12))
			0: begin
				h = 8'($urandom) | 8'h01;
				pending_words.push_back(h);
				if (h[7]) add_continued($urandom_range(1, 4), $urandom_range(0, 1));
			end
			1: begin
				pending_words.push_back(8'h04); add_continued($urandom_range(1, 5), 0);
			end
			2: begin
				pending_words.push_back(8'h08);
				add_random_bytes(m_ctx_size > 4 ? 4 : m_ctx_size);
				add_random_bytes(5);
			end
			3: begin
				pending_words.push_back(8'h70);
				add_continued($urandom_range(1, 5), 0);
				add_random_bytes(m_ctx_size > 4 ? 4 : m_ctx_size);
				h = 8'($urandom);
				if ($urandom_range(0, 3) != 0) h = (h & 8'h60) | 8'h09;
				pending_words.push_back(h);
				if ((h & 8'h9f) == 8'h09) add_random_bytes(4);
			end
			4: begin
				h = 8'($urandom) & 8'h6c;
				pending_words.push_back(h);
				if (header_kind(h) == tpp_pkg::KIND_OOO) add_random_bytes(h[3:2]);
			end
			5, 6: begin
				h = (8'($urandom) & 8'hac) | ($urandom_range(0, 1) ? 8'h50 : 8'h02);
				pending_words.push_back(h);
				if (h[5] && (header_kind(h) == tpp_pkg::KIND_PLACEHOLDER ||
					header_kind(h) == tpp_pkg::KIND_DATA))
					add_continued($urandom_range(1, 5), 0);
			end
			7: begin
				pending_words.push_back(8'h6e);
				add_random_bytes(m_ctx_size > 4 ? 4 : m_ctx_size);
			end
			8, 9, 10: pending_words.push_back((8'($urandom) | 8'h80) & 8'hfe);
			default: pending_words.push_back(8'($urandom));
		endcase
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || in_valid || expected_packets.size() != 0)
			@(posedge clk);
		repeat (Latency + 6) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [2:0] val);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		if (idx == tpp_pkg::REG_CONTEXT_SIZE) m_ctx_size = val; else m_cyc_acc = val[0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [2:0] sizes[6] = '{3'd0, 3'd4, 3'd7, 3'd1, 3'd2, 3'd3};
		m_ctx_size = 0; m_cyc_acc = 0; m_phase = P_HEADER; m_idx = 0;
		m_hdr = 0; m_addr = 0; m_cyc = 0; m_ctx = 0; m_data = 0; m_info = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words: fixed headers, longest branch, maximum fields.
		pending_words = '{8'h00, 8'h0c, 8'h50, 8'h62, 8'h66, 8'h6a, 8'h7a, 8'h76,
			8'h7e, 8'h72, 8'h10, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
			8'h04, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h6c, 8'hff, 8'hff};
		wait_drained();
		write_reg(tpp_pkg::REG_ATOM_TIMING, 3'd1);
		pending_words = '{8'h80, 8'hbc, 8'h82, 8'hfc, 8'h92, 8'h96, 8'h8a, 8'h08,
			8'h09, 8'hff, 8'hff, 8'hff, 8'hff};
		wait_drained();

		// Random packets across the register settings.
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(tpp_pkg::REG_CONTEXT_SIZE, sizes[ph % 6]);
			write_reg(tpp_pkg::REG_ATOM_TIMING, 3'(ph % 2));
			for (int n = 0; n < 30; n++) add_packet();
			wait_drained();
		end
		$display("Sent %0d stream words and checked %0d packets,", words_sent, packets_seen);
		$display("over all context sizes with plain and timed atom headers.");
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule

// File: sim.f
+incdir+design
design/tpp_pkg.sv
design/tpp_front.sv
design/tpp_queue.sv
design/tpp_back.sv
design/trace_packet_parser.sv
test/testbench.sv
